/* hdl/sidtd_pkg.sv */
// shared constants, state types and sizing function for the decimal text converter
package sidtd_pkg;

  localparam int VALUE_BITS_DEF = 32;

  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_MINUS = 8'd45;

  typedef enum logic [1:0] {
    C_IDLE,
    C_SHIFT,
    C_DONE
  } conv_state_t;

  typedef enum logic [1:0] {
    E_IDLE,
    E_SKIP,
    E_SIGN,
    E_DIGIT
  } emit_state_t;

  // decimal digits that hold any magnitude up to 2**bits
  function automatic int digits_for(input int bits);
    return ((bits * 1233) >> 12) + 1;
  endfunction

endpackage

/* hdl/sidtd_ifs.sv */
// stream interfaces for the integer input and the character output
interface sidtd_value_if #(
  parameter int W = sidtd_pkg::VALUE_BITS_DEF
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sidtd_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic       last_char;

  modport source (output valid, output char_out, output last_char, input ready);
  modport sink   (input valid, input char_out, input last_char, output ready);
endinterface

/* hdl/sidtd_conv.sv */
// bit-serial binary to bcd conversion of the input magnitude (shift and add three)
module sidtd_conv #(
  parameter int VALUE_BITS = sidtd_pkg::VALUE_BITS_DEF,
  parameter int NDIG       = sidtd_pkg::digits_for(sidtd_pkg::VALUE_BITS_DEF)
) (
  input  logic                 clk,
  input  logic                 rst,
  sidtd_value_if.sink          in_ch,
  output logic                 res_valid,
  input  logic                 res_ready,
  output logic                 res_neg,
  output logic [4*NDIG-1:0]    res_bcd
);
  import sidtd_pkg::*;

  localparam int SW = $clog2(VALUE_BITS);

  conv_state_t state, state_next;

  logic [VALUE_BITS-1:0] mag;
  logic [4*NDIG-1:0]     bcd;
  logic [4*NDIG-1:0]     bcd_adj;
  logic [SW-1:0]         cnt;
  logic                  neg;
  logic                  accept;

  assign accept = in_ch.valid && in_ch.ready;

  always_comb begin
    state_next = state;
    case (state)
      C_IDLE:  if (in_ch.valid) state_next = C_SHIFT;
      C_SHIFT: if (cnt == '0) state_next = C_DONE;
      C_DONE:  if (res_ready) state_next = C_IDLE;
      default: state_next = C_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = 1'b0;
    res_valid   = 1'b0;
    case (state)
      C_IDLE:  in_ch.ready = 1'b1;
      C_DONE:  res_valid   = 1'b1;
      default: ;
    endcase
  end

  // each digit of five or more gets three added before the shift
  always_comb begin
    for (int d = 0; d < NDIG; d++) begin
      if (bcd[4*d +: 4] >= 4'd5) begin
        bcd_adj[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
      end else begin
        bcd_adj[4*d +: 4] = bcd[4*d +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      neg <= in_ch.value[VALUE_BITS-1];
      if (in_ch.value[VALUE_BITS-1]) begin
        mag <= ~in_ch.value + 1'b1;
      end else begin
        mag <= in_ch.value;
      end
      bcd <= '0;
      cnt <= SW'(VALUE_BITS - 1);
    end else if (state == C_SHIFT) begin
      bcd <= {bcd_adj[4*NDIG-2:0], mag[VALUE_BITS-1]};
      mag <= {mag[VALUE_BITS-2:0], 1'b0};
      cnt <= cnt - 1'b1;
    end
  end

  assign res_neg = neg;
  assign res_bcd = bcd;

endmodule

/* hdl/sidtd_emit.sv */
// character serializer: drops leading zeros, sends sign and digits one beat each
module sidtd_emit #(
  parameter int NDIG = sidtd_pkg::digits_for(sidtd_pkg::VALUE_BITS_DEF)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              load_valid,
  output logic              load_ready,
  input  logic              load_neg,
  input  logic [4*NDIG-1:0] load_bcd,
  sidtd_char_if.source      out_ch
);
  import sidtd_pkg::*;

  localparam int CW = $clog2(NDIG);

  emit_state_t state, state_next;

  logic [4*NDIG-1:0] digits;
  logic [CW-1:0]     left;
  logic              neg;
  logic [3:0]        top;
  logic              beat;

  assign top  = digits[4*NDIG-1 -: 4];
  assign beat = out_ch.valid && out_ch.ready;

  always_comb begin
    state_next = state;
    case (state)
      E_IDLE: if (load_valid) state_next = E_SKIP;
      E_SKIP: begin
        if (!(top == 4'd0 && left != '0)) begin
          state_next = neg ? E_SIGN : E_DIGIT;
        end
      end
      E_SIGN:  if (out_ch.ready) state_next = E_DIGIT;
      E_DIGIT: if (out_ch.ready && left == '0) state_next = E_IDLE;
      default: state_next = E_IDLE;
    endcase
  end

  always_comb begin
    load_ready       = 1'b0;
    out_ch.valid     = 1'b0;
    out_ch.char_out  = ASCII_ZERO + {4'd0, top};
    out_ch.last_char = 1'b0;
    case (state)
      E_IDLE: load_ready = 1'b1;
      E_SIGN: begin
        out_ch.valid    = 1'b1;
        out_ch.char_out = ASCII_MINUS;
      end
      E_DIGIT: begin
        out_ch.valid     = 1'b1;
        out_ch.last_char = (left == '0);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= E_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load_valid && load_ready) begin
      digits <= load_bcd;
      neg    <= load_neg;
      left   <= CW'(NDIG - 1);
    end else if ((state == E_SKIP && top == 4'd0 && left != '0) ||
                 (state == E_DIGIT && beat && left != '0)) begin
      digits <= {digits[4*NDIG-5:0], 4'd0};
      left   <= left - 1'b1;
    end
  end

endmodule

/* hdl/signed_int_to_decimal_ascii.sv */
// Signed integer to decimal ASCII text. Each accepted value is converted
// one magnitude bit per cycle in a shift-and-add-three BCD register, and the
// input side takes a new value only once the previous result is handed on.
// The finished digits pass to a separate character serializer, which works
// on one number while the next converts: it drops leading zeros (up to
// NDIG - 1) in a skip state, then sends one beat per character, sign first
// for negatives, digits most significant first, with last_char set on the
// final digit. Zero gives the single character '0'.
module signed_int_to_decimal_ascii #(
  parameter int VALUE_BITS = sidtd_pkg::VALUE_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  sidtd_value_if.sink  in_ch,
  sidtd_char_if.source out_ch
);
  import sidtd_pkg::*;

  localparam int NDIG = digits_for(VALUE_BITS);

  logic              res_valid;
  logic              res_ready;
  logic              res_neg;
  logic [4*NDIG-1:0] res_bcd;

  sidtd_conv #(
    .VALUE_BITS (VALUE_BITS),
    .NDIG       (NDIG)
  ) u_conv (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_neg   (res_neg),
    .res_bcd   (res_bcd)
  );

  sidtd_emit #(
    .NDIG (NDIG)
  ) u_emit (
    .clk        (clk),
    .rst        (rst),
    .load_valid (res_valid),
    .load_ready (res_ready),
    .load_neg   (res_neg),
    .load_bcd   (res_bcd),
    .out_ch     (out_ch)
  );

endmodule

/* hdl/sidtd_check.sv */
// port-level assertions for the decimal text converter and their bind
module sidtd_check (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] char_out,
  input logic       last_char
);
  import sidtd_pkg::*;

  // stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(char_out) && $stable(last_char))
    else $error("output beat changed while stalled");

  // converter is busy right after taking a value
  a_in_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted twice in a row");

  a_char_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> char_out == ASCII_MINUS ||
                  (char_out >= ASCII_ZERO && char_out <= ASCII_ZERO + 8'd9))
    else $error("character is neither minus nor digit");

  a_sign_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && char_out == ASCII_MINUS |-> !last_char)
    else $error("minus sign flagged as last character");

endmodule

bind signed_int_to_decimal_ascii sidtd_check u_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .char_out  (out_ch.char_out),
  .last_char (out_ch.last_char)
);
